// ===== src/snom_pkg.sv =====
// ----------------------------------------------------------------------------
// Sweep neighbor owner mapper package
// Shared widths, codes, the configuration bundle and small helpers.
// ----------------------------------------------------------------------------
package snom_pkg;

    localparam int MAX_GRID = 64;
    localparam int CW       = $clog2(MAX_GRID);
    localparam int GW       = $clog2(MAX_GRID + 1);
    localparam int PW       = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int RSH      = 24;
    localparam int RW       = RSH + 1;
    localparam int ID_W     = 18;
    localparam int NID_W    = 19;
    localparam int DEP_W    = 8;
    localparam int CFG_W    = 7;
    localparam int MODE_W   = 3;

    typedef enum logic [2:0] {
        FACE_YM,
        FACE_XP,
        FACE_YP,
        FACE_XM,
        FACE_ZM,
        FACE_ZP
    } t_face;

    typedef enum logic [2:0] {
        CFG_GRID_X,
        CFG_GRID_Y,
        CFG_GRID_Z,
        CFG_OVL_X,
        CFG_OVL_Y,
        CFG_OVL_Z,
        CFG_MODES
    } t_cfg_idx;

    typedef struct packed {
        logic [GW-1:0]     gx;
        logic [GW-1:0]     gy;
        logic [GW-1:0]     gz;
        logic [MODE_W-1:0] modes;
        logic [RW-1:0]     rgx;
        logic [RW-1:0]     rgy;
        logic [RW-1:0]     rgz;
        logic [RW-1:0]     rox;
        logic [RW-1:0]     roy;
        logic [RW-1:0]     roz;
        logic [GW-1:0]     pxc;
        logic [GW-1:0]     pyc;
        logic [GW-1:0]     mcz;
        logic [PW-1:0]     gxgy;
        logic [PW-1:0]     pxpy;
        logic [RW-1:0]     rmx;
        logic [RW-1:0]     rmy;
        logic [RW-1:0]     rmz;
    } t_cfg;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [2:0]    oct;
    } t_coord;

    function automatic logic [GW-1:0] sat_grid(input logic [CFG_W-1:0] v);
        logic [GW-1:0] r;
        if (v == '0) begin
            r = GW'(1);
        end else if (32'(v) > MAX_GRID) begin
            r = GW'(MAX_GRID);
        end else begin
            r = GW'(v);
        end
        return r;
    endfunction

endpackage

// ===== src/snom_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the saturated grid, overload and mode registers and derives the
// reciprocals and processor counts used by the datapath.
// ----------------------------------------------------------------------------
module snom_cfg
    import snom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    logic [GW-1:0]     r_gx, r_gy, r_gz, r_ox, r_oy, r_oz;
    logic [MODE_W-1:0] r_modes;
    logic [RW-1:0]     r_rgx, r_rgy, r_rgz, r_rox, r_roy, r_roz;
    logic [GW-1:0]     r_pxc, r_pyc, r_mcz;
    logic [PW-1:0]     r_gxgy, r_pxpy;
    logic [RW-1:0]     r_rmx, r_rmy, r_rmz;
    logic [RW-1:0]     w_rtab [0:MAX_GRID];
    logic [GW+RW-1:0]  n_px, n_py, n_pz;

    assign w_rtab[0] = '0;
    for (genvar g = 1; g <= MAX_GRID; g++) begin : gen_rtab
        localparam longint RV = ((longint'(1) << RSH) + g - 1) / g;
        assign w_rtab[g] = RW'(RV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx    <= GW'(1);
            r_gy    <= GW'(1);
            r_gz    <= GW'(1);
            r_ox    <= GW'(1);
            r_oy    <= GW'(1);
            r_oz    <= GW'(1);
            r_modes <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_X: r_gx    <= sat_grid(i_cfg_wdata);
                CFG_GRID_Y: r_gy    <= sat_grid(i_cfg_wdata);
                CFG_GRID_Z: r_gz    <= sat_grid(i_cfg_wdata);
                CFG_OVL_X:  r_ox    <= sat_grid(i_cfg_wdata);
                CFG_OVL_Y:  r_oy    <= sat_grid(i_cfg_wdata);
                CFG_OVL_Z:  r_oz    <= sat_grid(i_cfg_wdata);
                CFG_MODES:  r_modes <= i_cfg_wdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign n_px = (GW+RW)'(r_gx) * (GW+RW)'(r_rox);
    assign n_py = (GW+RW)'(r_gy) * (GW+RW)'(r_roy);
    assign n_pz = (GW+RW)'(r_gz) * (GW+RW)'(r_roz);

    always_ff @(posedge i_clk) begin
        r_rgx  <= w_rtab[r_gx];
        r_rgy  <= w_rtab[r_gy];
        r_rgz  <= w_rtab[r_gz];
        r_rox  <= w_rtab[r_ox];
        r_roy  <= w_rtab[r_oy];
        r_roz  <= w_rtab[r_oz];
        r_pxc  <= n_px[RSH +: GW];
        r_pyc  <= n_py[RSH +: GW];
        r_mcz  <= n_pz[RSH +: GW];
        r_gxgy <= PW'(PW'(r_gx) * PW'(r_gy));
        r_pxpy <= PW'(PW'(r_pxc) * PW'(r_pyc));
        r_rmx  <= w_rtab[r_pxc];
        r_rmy  <= w_rtab[r_pyc];
        r_rmz  <= w_rtab[r_mcz];
    end

    assign o_cfg = '{gx: r_gx, gy: r_gy, gz: r_gz, modes: r_modes,
                     rgx: r_rgx, rgy: r_rgy, rgz: r_rgz,
                     rox: r_rox, roy: r_roy, roz: r_roz,
                     pxc: r_pxc, pyc: r_pyc, mcz: r_mcz,
                     gxgy: r_gxgy, pxpy: r_pxpy,
                     rmx: r_rmx, rmy: r_rmy, rmz: r_rmz};

endmodule

// ===== src/snom_split.sv =====
// ----------------------------------------------------------------------------
// Coordinate split pipeline
// Six stages that split a linear id into x, y and z by reciprocal
// multiplication, one multiplier per stage.
// ----------------------------------------------------------------------------
module snom_split
    import snom_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [ID_W-1:0] i_id,
    input  logic [2:0]      i_oct,
    output logic            o_valid,
    output t_coord          o_coord
);

    localparam int PR_W = ID_W + RW;

    logic [5:0]      r_v;
    logic [ID_W-1:0] r1_id, r2_id, r2_q1, r2_m1, r3_q1, r4_q1, r4_q2, r4_m2;
    logic [ID_W-1:0] r5_q2, r6_q2, r6_m3;
    logic [PR_W-1:0] r1_p, r3_p, r5_p;
    logic [CW-1:0]   r3_x, r4_x, r5_x, r6_x, r5_y, r6_y;
    logic [2:0]      r1_oct, r2_oct, r3_oct, r4_oct, r5_oct, r6_oct;
    logic [ID_W-1:0] w_q1, w_q2, w_q3;

    assign w_q1 = r1_p[RSH +: ID_W];
    assign w_q2 = r3_p[RSH +: ID_W];
    assign w_q3 = r5_p[RSH +: ID_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_id  <= i_id;
            r1_oct <= i_oct;
            r1_p   <= PR_W'(i_id) * PR_W'(i_cfg.rgx);

            r2_id  <= r1_id;
            r2_oct <= r1_oct;
            r2_q1  <= w_q1;
            r2_m1  <= ID_W'(w_q1 * ID_W'(i_cfg.gx));

            r3_x   <= CW'(r2_id - r2_m1);
            r3_q1  <= r2_q1;
            r3_oct <= r2_oct;
            r3_p   <= PR_W'(r2_q1) * PR_W'(i_cfg.rgy);

            r4_x   <= r3_x;
            r4_q1  <= r3_q1;
            r4_oct <= r3_oct;
            r4_q2  <= w_q2;
            r4_m2  <= ID_W'(w_q2 * ID_W'(i_cfg.gy));

            r5_x   <= r4_x;
            r5_y   <= CW'(r4_q1 - r4_m2);
            r5_q2  <= r4_q2;
            r5_oct <= r4_oct;
            r5_p   <= PR_W'(r4_q2) * PR_W'(i_cfg.rgz);

            r6_x   <= r5_x;
            r6_y   <= r5_y;
            r6_q2  <= r5_q2;
            r6_oct <= r5_oct;
            r6_m3  <= ID_W'(w_q3 * ID_W'(i_cfg.gz));
        end
    end

    assign o_valid = r_v[5];
    assign o_coord = '{x: r6_x, y: r6_y, z: CW'(r6_q2 - r6_m3), oct: r6_oct};

endmodule

// ===== src/snom_face.sv =====
// ----------------------------------------------------------------------------
// Face sequencer and owner pipeline
// Steps one cellset through its six faces and computes neighbor and owner
// ids in a five-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module snom_face
    import snom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    input  t_coord           i_coord,
    output logic             o_take,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_face,
    output logic             o_at_boundary,
    output logic [NID_W-1:0] o_neighbor_id,
    output logic [NID_W-1:0] o_owner_id,
    output logic [DEP_W-1:0] o_sweep_depth,
    output logic             o_last_face
);

    localparam int QP_W = CW + RW;

    logic             r_busy;
    t_face            r_face;
    logic [CW-1:0]    r_x, r_y, r_z;
    logic [DEP_W-1:0] r_depth;
    logic [4:0]       r_fv;
    logic             w_en;

    t_face            r1_face, r2_face, r3_face, r4_face, r5_face;
    logic             r1_edge, r2_edge, r3_edge, r4_edge, r5_edge;
    logic [DEP_W-1:0] r1_dep, r2_dep, r3_dep, r4_dep, r5_dep;
    logic [CW-1:0]    r1_c [0:2];
    logic [CW-1:0]    r2_c [0:2];
    logic [CW-1:0]    r3_c [0:2];
    logic [QP_W-1:0]  r2_qp [0:2];
    logic [CW-1:0]    r3_q [0:2];
    logic [CW-1:0]    r3_qm [0:2];
    logic [PW-1:0]    r2_pa;
    logic [NID_W-1:0] r2_pb, r3_nid, r4_nid, r5_nid;
    logic [CW-1:0]    r4_p0;
    logic [NID_W-1:0] r4_oa, r4_ob, r5_own;

    logic             w_xlow, w_ylow, w_zlow;
    logic [DEP_W-1:0] w_dx, w_dy, w_dz;
    logic             n_edge;
    logic [CW-1:0]    n_c [0:2];
    logic [RW-1:0]    w_rdiv [0:2];
    logic [RW-1:0]    w_rmod [0:2];
    logic [GW-1:0]    w_mc [0:2];
    logic [CW-1:0]    w_p [0:2];

    assign w_en   = !r_fv[4] || !i_stall;
    assign o_take = i_in_valid && (!r_busy || (r_face == FACE_ZP && w_en));

    assign w_xlow = (i_coord.oct == 3'd1) || (i_coord.oct == 3'd2) ||
                    (i_coord.oct == 3'd5) || (i_coord.oct == 3'd6);
    assign w_ylow = (i_coord.oct == 3'd2) || (i_coord.oct == 3'd3) ||
                    (i_coord.oct == 3'd6) || (i_coord.oct == 3'd7);
    assign w_zlow = i_coord.oct[2];
    assign w_dx = w_xlow ? DEP_W'(i_coord.x) : DEP_W'(i_cfg.gx - GW'(1) - GW'(i_coord.x));
    assign w_dy = w_ylow ? DEP_W'(i_coord.y) : DEP_W'(i_cfg.gy - GW'(1) - GW'(i_coord.y));
    assign w_dz = w_zlow ? DEP_W'(i_coord.z) : DEP_W'(i_cfg.gz - GW'(1) - GW'(i_coord.z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_face <= FACE_YM;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_face <= FACE_YM;
        end else if (r_busy && w_en) begin
            if (r_face == FACE_ZP) begin
                r_busy <= 1'b0;
            end else begin
                r_face <= t_face'(r_face + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_x     <= i_coord.x;
            r_y     <= i_coord.y;
            r_z     <= i_coord.z;
            r_depth <= w_dx + w_dy + w_dz;
        end
    end

    always_comb begin
        n_edge = 1'b0;
        n_c[0] = r_x;
        n_c[1] = r_y;
        n_c[2] = r_z;
        unique case (r_face)
            FACE_YM: begin
                if (r_y == '0) n_edge = 1'b1;
                else n_c[1] = r_y - CW'(1);
            end
            FACE_XP: begin
                if (GW'(r_x) == i_cfg.gx - GW'(1)) n_edge = 1'b1;
                else n_c[0] = r_x + CW'(1);
            end
            FACE_YP: begin
                if (GW'(r_y) == i_cfg.gy - GW'(1)) n_edge = 1'b1;
                else n_c[1] = r_y + CW'(1);
            end
            FACE_XM: begin
                if (r_x == '0) n_edge = 1'b1;
                else n_c[0] = r_x - CW'(1);
            end
            FACE_ZM: begin
                if (r_z == '0) n_edge = 1'b1;
                else n_c[2] = r_z - CW'(1);
            end
            FACE_ZP: begin
                if (GW'(r_z) == i_cfg.gz - GW'(1)) n_edge = 1'b1;
                else n_c[2] = r_z + CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign w_rdiv[0] = i_cfg.rox;
    assign w_rdiv[1] = i_cfg.roy;
    assign w_rdiv[2] = i_cfg.roz;
    assign w_rmod[0] = i_cfg.rmx;
    assign w_rmod[1] = i_cfg.rmy;
    assign w_rmod[2] = i_cfg.rmz;
    assign w_mc[0]   = i_cfg.pxc;
    assign w_mc[1]   = i_cfg.pyc;
    assign w_mc[2]   = i_cfg.mcz;

    for (genvar a = 0; a < 3; a++) begin : gen_axis
        always_comb begin
            if (i_cfg.modes[a]) begin
                w_p[a] = r3_q[a];
            end else if (w_mc[a] == '0) begin
                w_p[a] = '0;
            end else begin
                w_p[a] = r3_c[a] - r3_qm[a];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r1_c[a]  <= n_c[a];
                r2_c[a]  <= r1_c[a];
                r2_qp[a] <= QP_W'(r1_c[a]) *
                            QP_W'(i_cfg.modes[a] ? w_rdiv[a] : w_rmod[a]);
                r3_c[a]  <= r2_c[a];
                r3_q[a]  <= r2_qp[a][RSH +: CW];
                r3_qm[a] <= CW'(PW'(r2_qp[a][RSH +: CW]) * PW'(w_mc[a]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[3:0], r_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_face <= r_face;
            r1_edge <= n_edge;
            r1_dep  <= r_depth;

            r2_face <= r1_face;
            r2_edge <= r1_edge;
            r2_dep  <= r1_dep;
            r2_pa   <= PW'(PW'(i_cfg.gx) * PW'(r1_c[1]));
            r2_pb   <= NID_W'(NID_W'(i_cfg.gxgy) * NID_W'(r1_c[2]));

            r3_face <= r2_face;
            r3_edge <= r2_edge;
            r3_dep  <= r2_dep;
            r3_nid  <= NID_W'(r2_c[0]) + NID_W'(r2_pa) + r2_pb;

            r4_face <= r3_face;
            r4_edge <= r3_edge;
            r4_dep  <= r3_dep;
            r4_nid  <= r3_nid;
            r4_p0   <= w_p[0];
            r4_oa   <= NID_W'(NID_W'(i_cfg.pxc) * NID_W'(w_p[1]));
            r4_ob   <= NID_W'(NID_W'(i_cfg.pxpy) * NID_W'(w_p[2]));

            r5_face <= r4_face;
            r5_edge <= r4_edge;
            r5_dep  <= r4_dep;
            r5_nid  <= r4_edge ? NID_W'(0) - NID_W'(r4_face) - NID_W'(1) : r4_nid;
            r5_own  <= r4_edge ? '1 : NID_W'(r4_p0) + r4_oa + r4_ob;
        end
    end

    assign o_valid       = r_fv[4];
    assign o_face        = r5_face;
    assign o_at_boundary = r5_edge;
    assign o_neighbor_id = r5_nid;
    assign o_owner_id    = r5_own;
    assign o_sweep_depth = r5_dep;
    assign o_last_face   = (r5_face == FACE_ZP);

`ifndef ASSERT_OFF
    a_last_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_face |-> o_face == FACE_ZP)
        else $error("last face flag on a face other than +z");

    a_boundary_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_boundary |-> o_owner_id == '1)
        else $error("boundary face with an owner");

    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_en && r_face != FACE_ZP |=> r_busy)
        else $error("face sequencer dropped a cellset early");

    a_take_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !r_busy || (r_face == FACE_ZP && w_en))
        else $error("cellset loaded while faces remain");
`endif

endmodule

// ===== src/sweep_neighbor_owner_mapper_core.sv =====
// An input passes the split and face pipelines to its first face result.
// Throughput: six face results per cellset, one per cycle while i_stall is
// low, set by the face sequencer feeding the single result channel.
// Reset: synchronous, active low; grids and overloads reset to 1, modes to 0,
// and derived configuration settles through its registers after a write.
// ----------------------------------------------------------------------------
// Sweep neighbor owner mapper core
// Splits a cellset id into coordinates and emits its six face neighbors
// with their owning processors and the sweep depth.
// ----------------------------------------------------------------------------
module sweep_neighbor_owner_mapper_core
    import snom_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [ID_W-1:0]         i_cellset_id,
    input  logic [2:0]              i_octant,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_face,
    output logic                    o_at_boundary,
    output logic signed [NID_W-1:0] o_neighbor_id,
    output logic signed [NID_W-1:0] o_owner_id,
    output logic [DEP_W-1:0]        o_sweep_depth,
    output logic                    o_last_face
);

    t_cfg             w_cfg;
    t_coord           w_coord;
    logic             w_sv, w_take, w_adv;
    logic [NID_W-1:0] w_nid, w_own;

    assign w_adv   = !w_sv || w_take;
    assign o_stall = !w_adv;

    snom_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    snom_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_id    (i_cellset_id),
        .i_oct   (i_octant),
        .o_valid (w_sv),
        .o_coord (w_coord)
    );

    snom_face u_face (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (w_sv),
        .i_coord       (w_coord),
        .o_take        (w_take),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_face        (o_face),
        .o_at_boundary (o_at_boundary),
        .o_neighbor_id (w_nid),
        .o_owner_id    (w_own),
        .o_sweep_depth (o_sweep_depth),
        .o_last_face   (o_last_face)
    );

    assign o_neighbor_id = signed'(w_nid);
    assign o_owner_id    = signed'(w_own);

endmodule
